FILE: hw/rtl/bpdc_pkg.sv
// ---------------------------------------------------------------------------
// bpdc_pkg: shared types and constants for the button press classifier
// Codes for item kinds and events, field widths and inter-module structs.
// ---------------------------------------------------------------------------
`default_nettype none

package bpdc_pkg;

	localparam int TIME_W   = 32;
	localparam int CFG_W    = 16;
	localparam int SHORT_W  = 4;
	localparam int CFG_IDX_W = 2;

	localparam logic [SHORT_W-1:0] SHORT_LIMIT = 4'd10;

	// Reset values of the configuration registers
	localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd50;
	localparam logic [CFG_W-1:0] LONG_RST     = 16'd1000;
	localparam logic [CFG_W-1:0] MENU_RST     = 16'd3000;

	typedef enum logic [1:0] {
		MODE_EDGE   = 2'd0,
		MODE_POLL   = 2'd1,
		MODE_INJECT = 2'd2,
		MODE_UNUSED = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		EV_NONE  = 2'd0,
		EV_SHORT = 2'd1,
		EV_LONG  = 2'd2,
		EV_MENU  = 2'd3
	} event_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE = 2'd0,
		REG_LONG     = 2'd1,
		REG_MENU     = 2'd2,
		REG_NONE     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [CFG_W-1:0] dbnc_hold;
		logic [CFG_W-1:0] long_hold;
		logic [CFG_W-1:0] menu_hold;
	} cfg_t;

	typedef struct packed {
		mode_t             mode;
		logic [TIME_W-1:0] time_ms;
		logic              pin_low;
	} req_t;

	typedef struct packed {
		event_t            event_res;
		logic [TIME_W-1:0] activity_time;
	} res_t;

endpackage

`default_nettype wire

FILE: hw/rtl/bpdc_cfg_regs.sv
// ---------------------------------------------------------------------------
// bpdc_cfg_regs: configuration register file
// Decodes the register index of each write request and holds the timings.
// ---------------------------------------------------------------------------
`default_nettype none

module bpdc_cfg_regs import bpdc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	// Always take a write request
	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	// Decode the index and update the addressed register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dbnc_hold <= DEBOUNCE_RST;
			cfg_q.long_hold <= LONG_RST;
			cfg_q.menu_hold <= MENU_RST;
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEBOUNCE: cfg_q.dbnc_hold <= cfg_data;
				REG_LONG:     cfg_q.long_hold <= cfg_data;
				REG_MENU:     cfg_q.menu_hold <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/bpdc_core.sv
// ---------------------------------------------------------------------------
// bpdc_core: press tracking state and event classification
// Applies one request per enabled cycle and presents its result combinationally.
// ---------------------------------------------------------------------------
`default_nettype none

module bpdc_core import bpdc_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic fire,
	input  wire req_t req,
	input  wire cfg_t cfg,
	output res_t      res
);

	logic               down_q;
	logic [TIME_W-1:0]  start_q;
	logic [TIME_W-1:0]  last_edge_q;
	logic [SHORT_W-1:0] short_q;
	logic               long_q;
	logic               menu_q;
	logic [TIME_W-1:0]  activity_q;

	logic               down_d;
	logic [TIME_W-1:0]  start_d;
	logic [TIME_W-1:0]  last_edge_d;
	logic [SHORT_W-1:0] short_d;
	logic               long_d;
	logic               menu_d;
	logic [TIME_W-1:0]  activity_d;
	event_t             ev;

	logic [TIME_W-1:0]  edge_gap;
	logic [TIME_W-1:0]  hold;
	logic               blanked;
	logic [SHORT_W-1:0] short_inc;

	// Wrapping time differences
	assign edge_gap  = req.time_ms - last_edge_q;
	assign hold      = req.time_ms - start_q;
	assign blanked   = edge_gap < {{(TIME_W-CFG_W+1){1'b0}}, cfg.dbnc_hold[CFG_W-1:1]};
	assign short_inc = (short_q < SHORT_LIMIT) ? short_q + 1'b1 : short_q;

	// Next state and event for the current request
	always_comb begin
		down_d      = down_q;
		start_d     = start_q;
		last_edge_d = last_edge_q;
		short_d     = short_q;
		long_d      = long_q;
		menu_d      = menu_q;
		activity_d  = activity_q;
		ev          = EV_NONE;
		case (req.mode)
			MODE_EDGE: begin
				if (!blanked) begin
					last_edge_d = req.time_ms;
					if (req.pin_low && !down_q) begin
						down_d  = 1'b1;
						start_d = req.time_ms;
					end else if (!req.pin_low && down_q) begin
						down_d = 1'b0;
						if (hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.menu_hold}) begin
							menu_d = 1'b1;
						end else if (hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_hold}) begin
							long_d = 1'b1;
						end else if (hold >= {{(TIME_W-CFG_W){1'b0}}, cfg.dbnc_hold}) begin
							short_d = short_inc;
						end
					end
				end
			end
			MODE_POLL: begin
				// Hand out menu first, then long, then one short
				if (menu_q) begin
					menu_d = 1'b0;
					ev     = EV_MENU;
				end else if (long_q) begin
					long_d = 1'b0;
					ev     = EV_LONG;
				end else if (short_q != '0) begin
					short_d = short_q - 1'b1;
					ev      = EV_SHORT;
				end
				if (ev != EV_NONE) begin
					activity_d = req.time_ms;
				end
			end
			MODE_INJECT: begin
				short_d = short_inc;
			end
			default: ;
		endcase
	end

	assign res.event_res     = ev;
	assign res.activity_time = activity_d;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			down_q      <= 1'b0;
			start_q     <= '0;
			last_edge_q <= '0;
			short_q     <= '0;
			long_q      <= 1'b0;
			menu_q      <= 1'b0;
			activity_q  <= '0;
		end else if (fire) begin
			down_q      <= down_d;
			start_q     <= start_d;
			last_edge_q <= last_edge_d;
			short_q     <= short_d;
			long_q      <= long_d;
			menu_q      <= menu_d;
			activity_q  <= activity_d;
		end
	end

	// Short count never passes its limit
	assert property (@(posedge clk) disable iff (!arst_n) short_q <= SHORT_LIMIT)
		else $error("short count above limit");

	// Activity time moves only when a poll hands out an event
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ev == EV_NONE) |=> $stable(activity_q))
		else $error("activity time changed without an event");

	// A handed-out menu event clears the menu flag
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && ev == EV_MENU) |=> !menu_q)
		else $error("menu flag kept after hand-out");

	// Events come only from polls
	assert property (@(posedge clk) disable iff (!arst_n)
		(fire && req.mode != MODE_POLL) |-> ev == EV_NONE)
		else $error("event outside a poll");

endmodule

`default_nettype wire

FILE: hw/rtl/button_press_duration_classifier.sv
// ---------------------------------------------------------------------------
// button_press_duration_classifier: short, long and menu press detector
// Input register, classification core and output register for one button.
// ---------------------------------------------------------------------------
// Usage:
//   Slave stream: tuser carries the item kind (pin edge, poll, inject short),
//   tdata carries the timestamp and pin level. Master stream returns exactly
//   one result per request: event code and last activity timestamp.
//   Configuration channel writes debounce, long and menu hold times by index;
//   write only while no request is in flight.
//   Flow: an accepted request lands in the input register and is classified
//   into the output register once that register is free or being drained,
//   and its result is then presented on the master side. Throughput is one
//   request per cycle while m_tready stays high, set by the core state update.
//   Stall: when the receiver holds tready low, the output register keeps its
//   result, the input register holds one more request, and then the slave
//   side drops tready until the result is taken.
//   Reset: arst_n clears all press state, pending events and the activity
//   time, and restores the default timings (50, 1000, 3000 ms).
// ---------------------------------------------------------------------------
`default_nettype none

module button_press_duration_classifier import bpdc_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 s_tvalid,
	output logic                      s_tready,
	input  wire logic [39:0]          s_tdata,   // time_ms[31:0], pin_low[32], zero pad
	input  wire logic [1:0]           s_tuser,   // mode[1:0]
	output logic                      m_tvalid,
	input  wire logic                 m_tready,
	output logic [39:0]               m_tdata,   // event_res[1:0], activity_time[33:2], pad
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data
);

	logic  valid_s1;
	req_t  req_s1;
	logic  out_valid_q;
	res_t  out_q;
	logic  advance;
	cfg_t  cfg;
	res_t  res;

	// Move a request forward when the output register is free or being drained
	assign advance  = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || advance;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			req_s1.mode    <= mode_t'(s_tuser);
			req_s1.time_ms <= s_tdata[TIME_W-1:0];
			req_s1.pin_low <= s_tdata[TIME_W];
		end
	end

	bpdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	bpdc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.req    (req_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {6'd0, out_q.activity_time, out_q.event_res};

	// A stalled output with a full input register blocks new requests
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid_q && !m_tready) |-> !s_tready)
		else $error("request accepted with both registers full");

	// A pending request always moves into a free output register
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !out_valid_q) |=> out_valid_q)
		else $error("request not forwarded to free output register");

	// Hold a stalled result until it is taken
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("result changed while stalled");

endmodule

`default_nettype wire
